/* design/ffea_pkg.sv */
`timescale 1ns / 1ps

package ffea_pkg;

    localparam int MAP_ENTRIES_DEF = 64;
    localparam int UNIT_BITS_DEF   = 16;

    // operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_DONE       = 2'd0;
    localparam logic [1:0] STATUS_NO_FIT     = 2'd1;
    localparam logic [1:0] STATUS_TABLE_FULL = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ARD,
        S_ACHK,
        S_DRD,
        S_DWR,
        S_FRD,
        S_FCHK,
        S_FDEC,
        S_URD,
        S_UWR,
        S_UINS,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [15:0] base;
        logic [1:0]  status;
    } t_result;

endpackage

/* design/ffea_ram.sv */
`timescale 1ns / 1ps

module ffea_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/ffea_engine.sv */
`timescale 1ns / 1ps

module ffea_engine #(
    parameter int MAP_ENTRIES = ffea_pkg::MAP_ENTRIES_DEF,
    parameter int UNIT_BITS   = ffea_pkg::UNIT_BITS_DEF,
    localparam int IW         = $clog2(MAP_ENTRIES),
    localparam int CW         = $clog2(MAP_ENTRIES + 1),
    localparam int UW         = UNIT_BITS,
    localparam int RW         = 2 * UNIT_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request side
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic              i_operation,
    input  logic [15:0]       i_request_size,
    input  logic [15:0]       i_block_base,
    // result side
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output ffea_pkg::t_result o_res,
    // extent table memory
    output logic              o_we,
    output logic [IW-1:0]     o_waddr,
    output logic [RW-1:0]     o_wdata,
    output logic [IW-1:0]     o_raddr,
    input  logic [RW-1:0]     i_rdata
);

    localparam logic [CW-1:0] FULL_CNT  = CW'(MAP_ENTRIES);
    localparam logic [UW:0]   SPACE_TOP = {1'b1, {UW{1'b0}}};

    ffea_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_j, n_j;
    logic [UW-1:0] r_size, n_size;
    logic [UW-1:0] r_a, n_a;
    logic [UW-1:0] r_prev_base, n_prev_base;
    logic [UW-1:0] r_prev_len, n_prev_len;
    logic [UW-1:0] r_cur_base, n_cur_base;
    logic [UW-1:0] r_cur_len, n_cur_len;
    logic [15:0]   r_res_base, n_res_base;
    logic [1:0]    r_res_status, n_res_status;

    logic [UW-1:0] rd_base, rd_len;
    logic [UW-1:0] in_size, in_a, clip_size;
    logic [UW:0]   in_end, prev_end, prev_grow, free_end;
    logic [UW+1:0] total;
    logic          below, above;
    logic [CW-1:0] k_inc, k_dec, j_inc, j_dec;

    assign rd_base = i_rdata[UW-1:0];
    assign rd_len  = i_rdata[RW-1:UW];

    // inputs cut to the unit width, free clipped at the top of the space
    assign in_size   = UW'(i_request_size);
    assign in_a      = UW'(i_block_base);
    assign in_end    = {1'b0, in_a} + {1'b0, in_size};
    assign clip_size = (in_end > SPACE_TOP) ? UW'(SPACE_TOP - {1'b0, in_a}) : in_size;

    // merge decision for a free
    assign prev_end  = {1'b0, r_prev_base} + {1'b0, r_prev_len};
    assign prev_grow = {1'b0, r_prev_len} + {1'b0, r_size};
    assign free_end  = {1'b0, r_a} + {1'b0, r_size};
    assign below     = (r_k != '0) && (prev_end == {1'b0, r_a}) && !prev_grow[UW];
    assign total     = {2'b00, r_size} + {2'b00, r_cur_len}
                     + (below ? {2'b00, r_prev_len} : {(UW + 2){1'b0}});
    assign above     = (r_k < r_count) && (free_end == {1'b0, r_cur_base})
                     && (total[UW+1:UW] == 2'b00);

    assign k_inc = r_k + CW'(1);
    assign k_dec = r_k - CW'(1);
    assign j_inc = r_j + CW'(1);
    assign j_dec = r_j - CW'(1);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_k          = r_k;
        n_j          = r_j;
        n_size       = r_size;
        n_a          = r_a;
        n_prev_base  = r_prev_base;
        n_prev_len   = r_prev_len;
        n_cur_base   = r_cur_base;
        n_cur_len    = r_cur_len;
        n_res_base   = r_res_base;
        n_res_status = r_res_status;
        o_s_tready   = 1'b0;
        o_res_valid  = 1'b0;
        o_we         = 1'b0;
        o_waddr      = r_k[IW-1:0];
        o_wdata      = '0;
        o_raddr      = r_k[IW-1:0];

        unique case (r_state)
            ffea_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_a          = in_a;
                    n_k          = '0;
                    n_res_base   = '0;
                    n_res_status = ffea_pkg::STATUS_DONE;
                    if (i_operation == ffea_pkg::OP_ALLOC) begin
                        n_size = in_size;
                        if (r_count == '0) begin
                            n_res_status = ffea_pkg::STATUS_NO_FIT;
                            n_state      = ffea_pkg::S_RESP;
                        end else begin
                            n_state = ffea_pkg::S_ARD;
                        end
                    end else begin
                        n_size = clip_size;
                        if (in_size == '0) begin
                            n_state = ffea_pkg::S_RESP;
                        end else if (r_count == '0) begin
                            n_state = ffea_pkg::S_FDEC;
                        end else begin
                            n_state = ffea_pkg::S_FRD;
                        end
                    end
                end
            end
            ffea_pkg::S_ARD: begin
                n_state = ffea_pkg::S_ACHK;
            end
            ffea_pkg::S_ACHK: begin
                if (rd_len >= r_size) begin
                    n_res_base = 16'(rd_base);
                    if (rd_len == r_size) begin
                        n_j = r_k;
                        if (k_inc < r_count) begin
                            n_state = ffea_pkg::S_DRD;
                        end else begin
                            n_count = r_count - CW'(1);
                            n_state = ffea_pkg::S_RESP;
                        end
                    end else begin
                        o_we    = 1'b1;
                        o_waddr = r_k[IW-1:0];
                        o_wdata = {rd_len - r_size, rd_base + r_size};
                        n_state = ffea_pkg::S_RESP;
                    end
                end else begin
                    n_k = k_inc;
                    if (k_inc == r_count) begin
                        n_res_status = ffea_pkg::STATUS_NO_FIT;
                        n_state      = ffea_pkg::S_RESP;
                    end else begin
                        n_state = ffea_pkg::S_ARD;
                    end
                end
            end
            ffea_pkg::S_DRD: begin
                o_raddr = j_inc[IW-1:0];
                n_state = ffea_pkg::S_DWR;
            end
            ffea_pkg::S_DWR: begin
                o_we    = 1'b1;
                o_waddr = r_j[IW-1:0];
                o_wdata = i_rdata;
                n_j     = j_inc;
                if (r_j + CW'(2) < r_count) begin
                    n_state = ffea_pkg::S_DRD;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = ffea_pkg::S_RESP;
                end
            end
            ffea_pkg::S_FRD: begin
                n_state = ffea_pkg::S_FCHK;
            end
            ffea_pkg::S_FCHK: begin
                if (rd_base <= r_a) begin
                    n_prev_base = rd_base;
                    n_prev_len  = rd_len;
                    n_k         = k_inc;
                    n_state     = (k_inc == r_count) ? ffea_pkg::S_FDEC : ffea_pkg::S_FRD;
                end else begin
                    n_cur_base = rd_base;
                    n_cur_len  = rd_len;
                    n_state    = ffea_pkg::S_FDEC;
                end
            end
            ffea_pkg::S_FDEC: begin
                priority if (below && above) begin
                    o_we    = 1'b1;
                    o_waddr = k_dec[IW-1:0];
                    o_wdata = {total[UW-1:0], r_prev_base};
                    n_j     = r_k;
                    if (k_inc < r_count) begin
                        n_state = ffea_pkg::S_DRD;
                    end else begin
                        n_count = r_count - CW'(1);
                        n_state = ffea_pkg::S_RESP;
                    end
                end else if (below) begin
                    o_we    = 1'b1;
                    o_waddr = k_dec[IW-1:0];
                    o_wdata = {prev_grow[UW-1:0], r_prev_base};
                    n_state = ffea_pkg::S_RESP;
                end else if (above) begin
                    o_we    = 1'b1;
                    o_waddr = r_k[IW-1:0];
                    o_wdata = {total[UW-1:0], r_a};
                    n_state = ffea_pkg::S_RESP;
                end else if (r_count >= FULL_CNT) begin
                    n_res_status = ffea_pkg::STATUS_TABLE_FULL;
                    n_state      = ffea_pkg::S_RESP;
                end else if (r_count > r_k) begin
                    n_j     = r_count;
                    n_state = ffea_pkg::S_URD;
                end else begin
                    o_we    = 1'b1;
                    o_waddr = r_k[IW-1:0];
                    o_wdata = {r_size, r_a};
                    n_count = r_count + CW'(1);
                    n_state = ffea_pkg::S_RESP;
                end
            end
            ffea_pkg::S_URD: begin
                o_raddr = j_dec[IW-1:0];
                n_state = ffea_pkg::S_UWR;
            end
            ffea_pkg::S_UWR: begin
                o_we    = 1'b1;
                o_waddr = r_j[IW-1:0];
                o_wdata = i_rdata;
                n_j     = j_dec;
                n_state = (j_dec > r_k) ? ffea_pkg::S_URD : ffea_pkg::S_UINS;
            end
            ffea_pkg::S_UINS: begin
                o_we    = 1'b1;
                o_waddr = r_k[IW-1:0];
                o_wdata = {r_size, r_a};
                n_count = r_count + CW'(1);
                n_state = ffea_pkg::S_RESP;
            end
            ffea_pkg::S_RESP: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ffea_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ffea_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffea_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k          <= n_k;
        r_j          <= n_j;
        r_size       <= n_size;
        r_a          <= n_a;
        r_prev_base  <= n_prev_base;
        r_prev_len   <= n_prev_len;
        r_cur_base   <= n_cur_base;
        r_cur_len    <= n_cur_len;
        r_res_base   <= n_res_base;
        r_res_status <= n_res_status;
    end

    assign o_res.base   = r_res_base;
    assign o_res.status = r_res_status;

endmodule

/* design/ffea_out_reg.sv */
`timescale 1ns / 1ps

module ffea_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_valid,
    output logic              o_res_ready,
    input  ffea_pkg::t_result i_res,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output ffea_pkg::t_result o_res
);

    logic              r_valid;
    ffea_pkg::t_result r_res;

    assign o_res_ready = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_res_valid && o_res_ready) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_valid && o_res_ready) begin
            r_res <= i_res;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_res      = r_res;

endmodule

/* design/first_fit_extent_allocator.sv */
`timescale 1ns / 1ps
// sequence: each table entry is read in a read and a check state and each entry moved
//   in a read and a write state, then the response state and the output register follow;
//   a free adds the merge decision state and, when entries move up, the insert state; an
//   empty-map allocate or a zero-size free goes straight to the response state
// throughput: one request at a time, set by the read-then-write loop around the single
//   extent table memory
// reset: synchronous, active low; clearing the fill count empties the map at once, so
//   there is no clearing pass and a request may be taken in the first cycle after reset

module first_fit_extent_allocator #(
    parameter int MAP_ENTRIES = ffea_pkg::MAP_ENTRIES_DEF,  // 4 .. 1024
    parameter int UNIT_BITS   = ffea_pkg::UNIT_BITS_DEF     // 8 .. 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [15:0] request_size, [31:16] block_base
    input  logic [0:0]  i_s_tuser,   // [0] operation
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [15:0] granted_base
    output logic [1:0]  o_m_tuser    // [1:0] status
);

    localparam int IW = $clog2(MAP_ENTRIES);
    localparam int RW = 2 * UNIT_BITS;

    // engine to output register
    logic              res_valid;
    logic              res_ready;
    ffea_pkg::t_result eng_res;
    ffea_pkg::t_result out_res;

    // extent table port, each word holds {length, base}
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [RW-1:0] ram_wdata;
    logic [IW-1:0] ram_raddr;
    logic [RW-1:0] ram_rdata;

    // sequencer: scans, trims, merges and shifts the table one entry at a time
    ffea_engine #(
        .MAP_ENTRIES (MAP_ENTRIES),
        .UNIT_BITS   (UNIT_BITS)
    ) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (i_s_tvalid),
        .o_s_tready     (o_s_tready),
        .i_operation    (i_s_tuser[0]),
        .i_request_size (i_s_tdata[15:0]),
        .i_block_base   (i_s_tdata[31:16]),
        .o_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .o_res          (eng_res),
        .o_we           (ram_we),
        .o_waddr        (ram_waddr),
        .o_wdata        (ram_wdata),
        .o_raddr        (ram_raddr),
        .i_rdata        (ram_rdata)
    );

    // free-extent table, registered read
    ffea_ram #(
        .WIDTH (RW),
        .DEPTH (MAP_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // result holding stage, frees the engine while a transfer waits downstream
    ffea_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .o_res_ready (res_ready),
        .i_res       (eng_res),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_res       (out_res)
    );

    assign o_m_tdata = out_res.base;
    assign o_m_tuser = out_res.status;

endmodule

/* design/ffea_checker.sv */
`timescale 1ns / 1ps

module ffea_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        i_s_tready,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] i_m_tdata,
    input logic [1:0]  i_m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser))
        else $error("result changed while stalled");

    // one request in flight: no transfer the cycle after one is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready |=> !i_s_tready)
        else $error("request taken while another is in flight");

    // failed requests grant no base
    a_fail_base_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (i_m_tuser != ffea_pkg::STATUS_DONE) |-> i_m_tdata == 16'd0)
        else $error("non-zero base on a failed request");

    // only defined status codes are offered
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tuser == ffea_pkg::STATUS_DONE)
                    || (i_m_tuser == ffea_pkg::STATUS_NO_FIT)
                    || (i_m_tuser == ffea_pkg::STATUS_TABLE_FULL))
        else $error("undefined status code");

    // nothing is offered straight after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result valid after reset");

endmodule

bind first_fit_extent_allocator ffea_checker u_ffea_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser)
);
